@@ design/bxds_pkg.sv @@
// Package with shared types and constants of the box average downsampler.
`default_nettype none

package bxds_pkg;

	// Pixel layout: four 8-bit channels packed in 32 bits
	localparam int CH_N  = 4;
	localparam int CH_W  = 8;
	localparam int PIX_W = CH_N * CH_W;

	// Per-channel running sum in the line store
	localparam int SUM_W = 16;
	localparam int ROW_W = CH_N * SUM_W;

	// Box area (factor squared) is at most 256
	localparam int AREA_W = 9;

	// Configuration register indexes
	localparam int REG_IDX_W  = 2;
	localparam int REG_DATA_W = 16;
	localparam logic [REG_IDX_W-1:0] REG_BOX_FACTOR   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	// Register widths and reset values
	localparam int FAC_W = 5;
	localparam int WID_W = 13;
	localparam int HGT_W = 16;
	localparam logic [FAC_W-1:0] FAC_RST = 5'd2;
	localparam logic [WID_W-1:0] WID_RST = 13'd4096;
	localparam logic [HGT_W-1:0] HGT_RST = 16'd4096;

	// Depth of the queue between accumulator and divider
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;

	// Finished box: channel sums, divisor and end-of-image flag
	typedef struct packed {
		logic [ROW_W-1:0]  sums;
		logic [AREA_W-1:0] area;
		logic              done;
	} box_sum_t;

endpackage

`default_nettype wire

@@ design/bxds_if.sv @@
// Handshake channel interfaces: pixel input, result output, configuration writes.
`default_nettype none

interface bxds_pix_if;
	logic                       valid;
	logic                       ready;
	logic [bxds_pkg::PIX_W-1:0] pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

interface bxds_res_if;
	logic                       valid;
	logic                       ready;
	logic [bxds_pkg::PIX_W-1:0] pixel_out;
	logic                       image_done;

	modport source (output valid, output pixel_out, output image_done, input ready);
	modport sink (input valid, input pixel_out, input image_done, output ready);
endinterface

interface bxds_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bxds_pkg::REG_IDX_W-1:0]  index;
	logic [bxds_pkg::REG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/bxds_front.sv @@
// Front end: raster counters, box classification and line store accumulation.
`default_nettype none

module bxds_front #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_FACTOR = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              restart,
	input  wire logic [bxds_pkg::FAC_W-1:0]        fac,
	input  wire logic [$clog2(MAX_WIDTH+1)-1:0]    wid,
	input  wire logic [bxds_pkg::HGT_W-1:0]        hgt,
	input  wire logic [bxds_pkg::AREA_W-1:0]       area,
	bxds_pix_if.sink                               pixels,
	output logic                                   q_push,
	output bxds_pkg::box_sum_t                     q_data,
	input  wire logic                              q_full
);

	localparam int DEPTH = MAX_WIDTH / 2;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int XW    = WW + 1;
	localparam int PW    = $clog2(MAX_FACTOR);
	localparam int RW    = bxds_pkg::HGT_W + 1;
	localparam int FW    = bxds_pkg::FAC_W;

	// Raster position
	logic [CW-1:0]              col_q;
	logic [bxds_pkg::HGT_W-1:0] row_q;
	logic [PW-1:0]              cph_q;
	logic [PW-1:0]              rph_q;
	logic [AW-1:0]              ocol_q;

	// Accumulate stage
	logic                          vld_s1;
	logic                          act_s1;
	logic                          first_s1;
	logic                          emit_s1;
	logic                          done_s1;
	logic [AW-1:0]                 idx_s1;
	logic [bxds_pkg::PIX_W-1:0]    pix_s1;
	logic [bxds_pkg::ROW_W-1:0]    rd_q;

	// Last line store write, for read-after-write forwarding
	logic                          lw_vld_q;
	logic [AW-1:0]                 lw_idx_q;
	logic [bxds_pkg::ROW_W-1:0]    lw_data_q;

	logic [bxds_pkg::ROW_W-1:0]    store_q [DEPTH];

	logic                          accept;
	logic                          adv;
	logic                          wr;
	logic [XW-1:0]                 cend;
	logic [RW-1:0]                 rend;
	logic                          in_box;
	logic                          first_c;
	logic                          last_c;
	logic                          done_c;
	logic [WW-1:0]                 col_n;
	logic [RW-1:0]                 row_n;
	logic [FW-1:0]                 cph_n;
	logic [FW-1:0]                 rph_n;
	logic [bxds_pkg::ROW_W-1:0]    base;
	logic [bxds_pkg::ROW_W-1:0]    sums;

	// Stage advances unless a finished box waits on a full queue
	assign adv           = !vld_s1 || !emit_s1 || !q_full;
	assign pixels.ready  = adv;
	assign accept        = pixels.valid && adv;

	// Classify the incoming pixel against whole boxes
	always_comb begin
		cend    = XW'(col_q) - XW'(cph_q) + XW'(fac);
		rend    = RW'(row_q) - RW'(rph_q) + RW'(fac);
		in_box  = (cend <= XW'(wid)) && (rend <= RW'(hgt));
		first_c = (cph_q == '0) && (rph_q == '0);
		last_c  = (FW'(cph_q) == fac - FW'(1)) && (FW'(rph_q) == fac - FW'(1));
		done_c  = last_c && ((cend + XW'(fac)) > XW'(wid))
			&& ((rend + RW'(fac)) > RW'(hgt));
		col_n   = WW'(col_q) + WW'(1);
		row_n   = RW'(row_q) + RW'(1);
		cph_n   = FW'(cph_q) + FW'(1);
		rph_n   = FW'(rph_q) + FW'(1);
	end

	// Raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			cph_q  <= '0;
			rph_q  <= '0;
			ocol_q <= '0;
		end else if (restart) begin
			col_q  <= '0;
			row_q  <= '0;
			cph_q  <= '0;
			rph_q  <= '0;
			ocol_q <= '0;
		end else if (accept) begin
			if (col_n >= wid) begin
				col_q  <= '0;
				cph_q  <= '0;
				ocol_q <= '0;
				if (row_n >= RW'(hgt)) begin
					row_q <= '0;
					rph_q <= '0;
				end else begin
					row_q <= row_n[bxds_pkg::HGT_W-1:0];
					rph_q <= (rph_n >= fac) ? '0 : rph_n[PW-1:0];
				end
			end else begin
				col_q <= col_n[CW-1:0];
				if (cph_n >= fac) begin
					cph_q  <= '0;
					ocol_q <= ocol_q + AW'(1);
				end else begin
					cph_q <= cph_n[PW-1:0];
				end
			end
		end
	end

	// Stage valid and last-write tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			lw_vld_q <= 1'b0;
		end else begin
			if (adv) begin
				vld_s1 <= accept;
			end
			if (wr) begin
				lw_vld_q <= 1'b1;
			end
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1   <= in_box;
			first_s1 <= first_c;
			emit_s1  <= in_box && last_c;
			done_s1  <= done_c;
			idx_s1   <= ocol_q;
			pix_s1   <= pixels.pixel_in;
		end
		if (wr) begin
			lw_idx_q  <= idx_s1;
			lw_data_q <= sums;
		end
	end

	// Add the pixel to the running column sums
	always_comb begin
		if (first_s1) begin
			base = '0;
		end else if (lw_vld_q && (lw_idx_q == idx_s1)) begin
			base = lw_data_q;
		end else begin
			base = rd_q;
		end
		for (int c = 0; c < bxds_pkg::CH_N; c++) begin
			sums[c*bxds_pkg::SUM_W +: bxds_pkg::SUM_W] =
				base[c*bxds_pkg::SUM_W +: bxds_pkg::SUM_W]
				+ bxds_pkg::SUM_W'(pix_s1[c*bxds_pkg::CH_W +: bxds_pkg::CH_W]);
		end
	end

	assign wr = vld_s1 && act_s1 && adv;

	// Line store: one read on accept, one write per in-box pixel
	always_ff @(posedge clk) begin
		if (wr) begin
			store_q[idx_s1] <= sums;
		end
		if (accept) begin
			rd_q <= store_q[ocol_q];
		end
	end

	// Finished box goes to the divider queue
	assign q_push      = vld_s1 && emit_s1 && !q_full;
	assign q_data.sums = sums;
	assign q_data.area = area;
	assign q_data.done = done_s1;

endmodule

`default_nettype wire

@@ design/bxds_queue.sv @@
// Short FIFO of finished box sums between accumulator and divider.
`default_nettype none

module bxds_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  bxds_pkg::box_sum_t      push_data,
	input  wire logic               pop,
	output bxds_pkg::box_sum_t      pop_data,
	output logic                    full,
	output logic                    empty
);

	localparam int CNT_W = bxds_pkg::Q_PTR_W + 1;

	bxds_pkg::box_sum_t             slot_q [bxds_pkg::Q_DEPTH];
	logic [bxds_pkg::Q_PTR_W-1:0]   wptr_q;
	logic [bxds_pkg::Q_PTR_W-1:0]   rptr_q;
	logic [CNT_W-1:0]               cnt_q;

	assign full     = (cnt_q == CNT_W'(bxds_pkg::Q_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = slot_q[rptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + bxds_pkg::Q_PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + bxds_pkg::Q_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

@@ design/bxds_back.sv @@
// Back end: restoring divider by box area, one quotient bit per cycle, and result register.
`default_nettype none

module bxds_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  bxds_pkg::box_sum_t q_data,
	input  wire logic          q_empty,
	output logic               q_pop,
	bxds_res_if.source         results
);

	localparam int SW = bxds_pkg::SUM_W;
	localparam int CN = bxds_pkg::CH_N;
	localparam int QW = bxds_pkg::CH_W;
	localparam int SHIFT = QW - 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_HOLD
	} state_t;

	state_t                  state_q;
	logic [SW-1:0]           rem_q [CN];
	logic [QW-1:0]           quo_q [CN];
	logic [SW-1:0]           dsh_q;
	logic [$clog2(QW)-1:0]   step_q;
	logic                    done_q;
	logic                    ovld_q;
	logic [bxds_pkg::PIX_W-1:0] opix_q;
	logic                    odone_q;

	logic [SW-1:0]           rem_n [CN];
	logic [CN-1:0]           qbit;

	assign q_pop              = (state_q == ST_IDLE) && !q_empty;
	assign results.valid      = ovld_q;
	assign results.pixel_out  = opix_q;
	assign results.image_done = odone_q;

	// One compare-subtract per channel
	always_comb begin
		for (int c = 0; c < CN; c++) begin
			qbit[c]  = (rem_q[c] >= dsh_q);
			rem_n[c] = qbit[c] ? (rem_q[c] - dsh_q) : rem_q[c];
		end
	end

	// Divider sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dsh_q   <= '0;
			step_q  <= '0;
			done_q  <= 1'b0;
			ovld_q  <= 1'b0;
			opix_q  <= '0;
			odone_q <= 1'b0;
			for (int c = 0; c < CN; c++) begin
				rem_q[c] <= '0;
				quo_q[c] <= '0;
			end
		end else begin
			// Output valid: set when a result loads, cleared when taken
			if ((state_q == ST_HOLD) && (!ovld_q || results.ready)) begin
				ovld_q <= 1'b1;
			end else if (ovld_q && results.ready) begin
				ovld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						for (int c = 0; c < CN; c++) begin
							rem_q[c] <= q_data.sums[c*SW +: SW];
						end
						dsh_q   <= SW'({q_data.area, SHIFT'(0)});
						done_q  <= q_data.done;
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					for (int c = 0; c < CN; c++) begin
						rem_q[c] <= rem_n[c];
						quo_q[c] <= {quo_q[c][QW-2:0], qbit[c]};
					end
					dsh_q  <= dsh_q >> 1;
					step_q <= step_q + ($clog2(QW))'(1);
					if (step_q == ($clog2(QW))'(QW - 1)) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (!ovld_q || results.ready) begin
						odone_q <= done_q;
						for (int c = 0; c < CN; c++) begin
							opix_q[c*QW +: QW] <= quo_q[c];
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/box_average_downsample.sv @@
// Top level of the box average downsampler: config registers, front, queue, divider.
// Accepts one pixel per cycle unless a finished box waits on a full queue; an
// in-box pixel does one line store read-add-write. Box sums pass the queue, the
// divider and result register. Input stalls only when finished boxes fill the queue.
// Reset clears counters and restores registers to factor 2, 4096 x 4096.
`default_nettype none

module box_average_downsample #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_FACTOR = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bxds_pix_if.sink   pixels,
	bxds_res_if.source results,
	bxds_cfg_if.sink   cfg
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int FW = bxds_pkg::FAC_W;

	logic [FW-1:0]                  fac_q;
	logic [bxds_pkg::WID_W-1:0]     wid_q;
	logic [bxds_pkg::HGT_W-1:0]     hgt_q;

	logic [FW-1:0]                  fac_c;
	logic [WW-1:0]                  wid_c;
	logic [bxds_pkg::HGT_W-1:0]     hgt_c;
	logic [bxds_pkg::AREA_W-1:0]    area_c;
	logic                           cfg_wr;
	logic                           restart;

	logic                           q_push;
	logic                           q_pop;
	logic                           q_full;
	logic                           q_empty;
	bxds_pkg::box_sum_t             q_in;
	bxds_pkg::box_sum_t             q_out;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid;
	assign restart   = cfg_wr && ((cfg.index == bxds_pkg::REG_BOX_FACTOR)
		|| (cfg.index == bxds_pkg::REG_IMAGE_WIDTH)
		|| (cfg.index == bxds_pkg::REG_IMAGE_HEIGHT));

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fac_q <= bxds_pkg::FAC_RST;
			wid_q <= bxds_pkg::WID_RST;
			hgt_q <= bxds_pkg::HGT_RST;
		end else if (cfg_wr) begin
			case (cfg.index)
				bxds_pkg::REG_BOX_FACTOR:   fac_q <= cfg.data[FW-1:0];
				bxds_pkg::REG_IMAGE_WIDTH:  wid_q <= cfg.data[bxds_pkg::WID_W-1:0];
				bxds_pkg::REG_IMAGE_HEIGHT: hgt_q <= cfg.data[bxds_pkg::HGT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Clamp registers to the supported ranges
	always_comb begin
		if (fac_q < FW'(2)) begin
			fac_c = FW'(2);
		end else if (32'(fac_q) > 32'(MAX_FACTOR)) begin
			fac_c = FW'(MAX_FACTOR);
		end else begin
			fac_c = fac_q;
		end
		if (wid_q < bxds_pkg::WID_W'(2)) begin
			wid_c = WW'(2);
		end else if (32'(wid_q) > 32'(MAX_WIDTH)) begin
			wid_c = WW'(MAX_WIDTH);
		end else begin
			wid_c = WW'(wid_q);
		end
		hgt_c  = (hgt_q < bxds_pkg::HGT_W'(2)) ? bxds_pkg::HGT_W'(2) : hgt_q;
		area_c = bxds_pkg::AREA_W'(fac_c) * bxds_pkg::AREA_W'(fac_c);
	end

	bxds_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_FACTOR (MAX_FACTOR)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.fac     (fac_c),
		.wid     (wid_c),
		.hgt     (hgt_c),
		.area    (area_c),
		.pixels  (pixels),
		.q_push  (q_push),
		.q_data  (q_in),
		.q_full  (q_full)
	);

	bxds_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.pop_data  (q_out),
		.full      (q_full),
		.empty     (q_empty)
	);

	bxds_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (q_out),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.results (results)
	);

`ifndef SYNTHESIS
	// Queue is never written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("box queue written while full");

	// Queue is never read while empty
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("box queue read while empty");

	// Pixel input stalls only behind a full queue
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pixels.ready |-> q_full)
		else $error("pixel input stalled without full queue");
`endif

endmodule

`default_nettype wire
